FILE: rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Holds the block record layout, sizes and the request and status codes.
// No dependencies.
package ffha_pkg;

    localparam int unsigned MAX_BLOCKS = 64;
    localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam int unsigned HEAP_BYTES = 65536;
    localparam int unsigned TOP_W      = $clog2(HEAP_BYTES + 1);

    // Request kinds carried in the input tuser.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // One entry of the block table.
    typedef struct packed {
        logic [TOP_W-1:0] start;
        logic [TOP_W-1:0] size;
        logic             used;
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] prev;
    } t_blk;

    localparam int unsigned BLK_W = $bits(t_blk);

    // Slot bitmap commands from the sequencer.
    typedef struct packed {
        logic             take_en;
        logic [IDX_W-1:0] take_idx;
        logic             drop0_en;
        logic [IDX_W-1:0] drop0_idx;
        logic             drop1_en;
        logic [IDX_W-1:0] drop1_idx;
    } t_slot_cmd;

endpackage

FILE: rtl/ffha_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ffha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ffha_slots.sv
// Slot occupancy bitmap of the block table with a lowest-free-slot encoder.
// Depends on ffha_pkg.
module ffha_slots import ffha_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_slot_cmd        i_cmd,
    output logic             o_avail,
    output logic [IDX_W-1:0] o_free_idx
);

    logic [MAX_BLOCKS-1:0] r_taken;
    logic [MAX_BLOCKS-1:0] n_taken;

    // Lowest free slot, searched from the top down so the lowest wins.
    always_comb begin
        o_free_idx = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_taken[i]) begin
                o_free_idx = IDX_W'(i);
            end
        end
    end

    assign o_avail = ~&r_taken;

    // Apply takes and drops.
    always_comb begin
        n_taken = r_taken;
        if (i_cmd.take_en) begin
            n_taken[i_cmd.take_idx] = 1'b1;
        end
        if (i_cmd.drop0_en) begin
            n_taken[i_cmd.drop0_idx] = 1'b0;
        end
        if (i_cmd.drop1_en) begin
            n_taken[i_cmd.drop1_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else begin
            r_taken <= n_taken;
        end
    end

    // A slot is only taken while it is free.
    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_en |-> (!r_taken[i_cmd.take_idx] && o_avail))
        else $error("slot taken twice");

    // Only linked slots are released on the first drop port.
    a_drop_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop0_en |-> r_taken[i_cmd.drop0_idx])
        else $error("released slot was not in use");

    // Two releases in one cycle name two different slots.
    a_drop_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.drop0_en && i_cmd.drop1_en) |-> (i_cmd.drop0_idx != i_cmd.drop1_idx))
        else $error("same slot released twice");

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: stream ports and request sequencer.
// Depends on ffha_pkg, ffha_ram and ffha_slots.
//
//  channel   direction  signals                          contents
//  config    in         i_cfg_valid/o_cfg_ready/data     header_bytes
//  request   in         s_axis_tvalid/tready/tdata/tuser request fields, tuser = action
//  result    out        m_axis_tvalid/tready/tdata       alloc_addr, status, heap_top
//
// Allocate walks the block list in the table RAM, reading and checking each block
// in turn over at most MAX_BLOCKS - 1 blocks, then marks or splits the block it
// found or appends a new block at the heap top.
// Free walks the same way to the block and then merges it with free neighbors.
// Reset is synchronous; no table clearing pass is needed, the block is ready at once.
// A request is taken only when the sequencer is idle; a result waiting in the
// output register holds the sequencer only when the next result is ready.
module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,      // header_bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // req_size[15:0], free_addr[31:16]
    input  logic [0:0]  s_axis_tuser,    // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // alloc_addr[15:0], status[17:16], heap_top[34:18]
);

    typedef enum logic [4:0] {
        S_IDLE, S_AWALK, S_ACHK, S_ASRD, S_ASWN, S_ASWS, S_ASWC, S_APP, S_ATW, S_AWS,
        S_FWALK, S_FCHK, S_FTP, S_FNPC, S_FNRD, S_FNC, S_FNNR, S_FNNW, S_FNPW, S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_hdr;
    logic [IDX_W-1:0] r_head, n_head, r_tail, n_tail;
    logic             r_empty, n_empty;
    logic [TOP_W-1:0] r_top, n_top;
    logic [TOP_W-1:0] r_total, n_total;
    logic [15:0]      r_faddr, n_faddr;
    logic [IDX_W-1:0] r_cur, n_cur, r_s, n_s, r_x, n_x;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_blk             r_b, n_b, r_p, n_p, r_n, n_n;
    logic             r_mp, n_mp;
    logic [15:0]      r_res_addr, n_res_addr;
    logic [1:0]       r_res_st, n_res_st;
    logic             r_m_valid, n_m_valid;
    logic [39:0]      r_m_data, n_m_data;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    t_blk             mem_wdata, mem_rdata;
    logic [BLK_W-1:0] mem_rbits;
    t_slot_cmd        slot_cmd;
    logic             slot_avail;
    logic [IDX_W-1:0] slot_free;

    ffha_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rbits)
    );
    assign mem_rdata = t_blk'(mem_rbits);

    ffha_slots u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (slot_cmd),
        .o_avail    (slot_avail),
        .o_free_idx (slot_free)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Request sequencer: walks and edits the block table.
    always_comb begin
        t_blk             w;
        logic [TOP_W+1:0] end_sum;
        logic [TOP_W+1:0] pay_sum;
        logic [TOP_W-1:0] rest;
        logic [IDX_W-1:0] xi;
        logic             mn;

        n_state = r_state;   n_head = r_head;     n_tail = r_tail;
        n_empty = r_empty;   n_top = r_top;       n_total = r_total;
        n_faddr = r_faddr;   n_cur = r_cur;       n_s = r_s;
        n_x = r_x;           n_cnt = r_cnt;       n_b = r_b;
        n_p = r_p;           n_n = r_n;           n_mp = r_mp;
        n_res_addr = r_res_addr;                  n_res_st = r_res_st;
        n_m_valid = r_m_valid;                    n_m_data = r_m_data;
        mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;
        mem_re = 1'b0;  mem_raddr = '0;
        slot_cmd = '0;
        w = mem_rdata;
        end_sum = {2'b00, r_top} + {2'b00, r_total};
        pay_sum = {2'b00, mem_rdata.start} + {{(TOP_W - 6){1'b0}}, r_hdr};
        rest = mem_rdata.size - r_total;
        xi = r_mp ? r_b.prev : r_cur;
        mn = !mem_rdata.used;

        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_total = {{(TOP_W - 8){1'b0}}, r_hdr} + {1'b0, s_axis_tdata[15:0]};
                    n_faddr = s_axis_tdata[31:16];
                    n_cur = r_head;
                    n_cnt = '0;
                    n_res_addr = '0;
                    n_res_st = ST_OK;
                    if (s_axis_tuser[0] == ACT_ALLOC) begin
                        n_state = r_empty ? S_APP : S_AWALK;
                    end else if (r_empty) begin
                        n_res_st = ST_UNKNOWN;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FWALK;
                    end
                end
            end
            // First-fit walk; the tail block is never split or reused.
            S_AWALK: begin
                if (r_cnt == CNT_W'(MAX_BLOCKS) || r_cur == r_tail) begin
                    n_state = S_APP;
                end else begin
                    mem_re = 1'b1;
                    mem_raddr = r_cur;
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (!mem_rdata.used && mem_rdata.size >= r_total) begin
                    n_b = mem_rdata;
                    n_res_addr = pay_sum[15:0];
                    if (rest > {{(TOP_W - 8){1'b0}}, r_hdr} && slot_avail) begin
                        slot_cmd.take_en = 1'b1;
                        slot_cmd.take_idx = slot_free;
                        n_s = slot_free;
                        n_state = S_ASRD;
                    end else begin
                        w.used = 1'b1;
                        mem_we = 1'b1;
                        mem_waddr = r_cur;
                        mem_wdata = w;
                        n_state = S_DONE;
                    end
                end else begin
                    n_cur = mem_rdata.next;
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_AWALK;
                end
            end
            S_ASRD: begin
                mem_re = 1'b1;
                mem_raddr = r_b.next;
                n_state = S_ASWN;
            end
            S_ASWN: begin
                w.prev = r_s;
                mem_we = 1'b1;
                mem_waddr = r_b.next;
                mem_wdata = w;
                n_state = S_ASWS;
            end
            S_ASWS: begin
                w.start = r_b.start + r_total;
                w.size = r_b.size - r_total;
                w.used = 1'b0;
                w.prev = r_cur;
                w.next = r_b.next;
                mem_we = 1'b1;
                mem_waddr = r_s;
                mem_wdata = w;
                n_state = S_ASWC;
            end
            S_ASWC: begin
                w = r_b;
                w.size = r_total;
                w.used = 1'b1;
                w.next = r_s;
                mem_we = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = w;
                n_state = S_DONE;
            end
            // Append a new block at the heap top.
            S_APP: begin
                n_res_addr = 16'(r_top + {{(TOP_W - 8){1'b0}}, r_hdr});
                if (end_sum > (TOP_W + 2)'(HEAP_BYTES)) begin
                    n_res_addr = '0;
                    n_res_st = ST_NOSPACE;
                    n_state = S_DONE;
                end else if (!slot_avail) begin
                    n_res_addr = '0;
                    n_res_st = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    slot_cmd.take_en = 1'b1;
                    slot_cmd.take_idx = slot_free;
                    n_s = slot_free;
                    if (r_empty) begin
                        w.start = r_top;
                        w.size = r_total;
                        w.used = 1'b1;
                        w.next = '0;
                        w.prev = '0;
                        mem_we = 1'b1;
                        mem_waddr = slot_free;
                        mem_wdata = w;
                        n_head = slot_free;
                        n_tail = slot_free;
                        n_empty = 1'b0;
                        n_top = end_sum[TOP_W-1:0];
                        n_state = S_DONE;
                    end else begin
                        mem_re = 1'b1;
                        mem_raddr = r_tail;
                        n_state = S_ATW;
                    end
                end
            end
            S_ATW: begin
                w.next = r_s;
                mem_we = 1'b1;
                mem_waddr = r_tail;
                mem_wdata = w;
                n_state = S_AWS;
            end
            S_AWS: begin
                w.start = r_top;
                w.size = r_total;
                w.used = 1'b1;
                w.next = '0;
                w.prev = r_tail;
                mem_we = 1'b1;
                mem_waddr = r_s;
                mem_wdata = w;
                n_tail = r_s;
                n_top = end_sum[TOP_W-1:0];
                n_state = S_DONE;
            end
            // Search for the used block with the given payload offset.
            S_FWALK: begin
                if (r_cnt == CNT_W'(MAX_BLOCKS)) begin
                    n_res_st = ST_UNKNOWN;
                    n_state = S_DONE;
                end else begin
                    mem_re = 1'b1;
                    mem_raddr = r_cur;
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_b = mem_rdata;
                if (mem_rdata.used && pay_sum == {3'b000, r_faddr}) begin
                    if (r_cur == r_tail) begin
                        if (r_cur == r_head) begin
                            slot_cmd.drop0_en = 1'b1;
                            slot_cmd.drop0_idx = r_cur;
                            n_top = mem_rdata.start;
                            n_empty = 1'b1;
                            n_head = '0;
                            n_tail = '0;
                            n_state = S_DONE;
                        end else begin
                            mem_re = 1'b1;
                            mem_raddr = mem_rdata.prev;
                            n_state = S_FTP;
                        end
                    end else if (r_cur != r_head) begin
                        mem_re = 1'b1;
                        mem_raddr = mem_rdata.prev;
                        n_state = S_FNPC;
                    end else begin
                        n_mp = 1'b0;
                        n_state = S_FNRD;
                    end
                end else if (r_cur == r_tail) begin
                    n_res_st = ST_UNKNOWN;
                    n_state = S_DONE;
                end else begin
                    n_cur = mem_rdata.next;
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_FWALK;
                end
            end
            // Freed tail block: drop it, and a free block before it, off the top.
            S_FTP: begin
                slot_cmd.drop0_en = 1'b1;
                slot_cmd.drop0_idx = r_cur;
                if (!mem_rdata.used) begin
                    slot_cmd.drop1_en = 1'b1;
                    slot_cmd.drop1_idx = r_b.prev;
                    n_top = mem_rdata.start;
                    if (r_b.prev == r_head) begin
                        n_empty = 1'b1;
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_tail = mem_rdata.prev;
                    end
                end else begin
                    n_top = r_b.start;
                    n_tail = r_b.prev;
                end
                n_state = S_DONE;
            end
            S_FNPC: begin
                n_p = mem_rdata;
                n_mp = !mem_rdata.used;
                n_state = S_FNRD;
            end
            S_FNRD: begin
                mem_re = 1'b1;
                mem_raddr = r_b.next;
                n_state = S_FNC;
            end
            // Merge with free neighbors and write the surviving block.
            S_FNC: begin
                n_n = mem_rdata;
                n_x = xi;
                w.start = r_mp ? r_p.start : r_b.start;
                w.prev = r_mp ? r_p.prev : r_b.prev;
                w.size = (r_mp ? r_p.size + r_b.size : r_b.size)
                         + (mn ? mem_rdata.size : {TOP_W{1'b0}});
                w.next = mn ? mem_rdata.next : r_b.next;
                w.used = 1'b0;
                mem_we = 1'b1;
                mem_waddr = xi;
                mem_wdata = w;
                if (r_mp) begin
                    slot_cmd.drop0_en = 1'b1;
                    slot_cmd.drop0_idx = r_cur;
                end
                if (mn) begin
                    slot_cmd.drop1_en = 1'b1;
                    slot_cmd.drop1_idx = r_b.next;
                    if (r_b.next == r_tail) begin
                        n_tail = xi;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FNNR;
                    end
                end else begin
                    n_state = r_mp ? S_FNPW : S_DONE;
                end
            end
            S_FNNR: begin
                mem_re = 1'b1;
                mem_raddr = r_n.next;
                n_state = S_FNNW;
            end
            S_FNNW: begin
                w.prev = r_x;
                mem_we = 1'b1;
                mem_waddr = r_n.next;
                mem_wdata = w;
                n_state = S_DONE;
            end
            S_FNPW: begin
                w = r_n;
                w.prev = r_b.prev;
                mem_we = 1'b1;
                mem_waddr = r_b.next;
                mem_wdata = w;
                n_state = S_DONE;
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data = {5'b0, r_top, r_res_st, r_res_addr};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hdr     <= 8'd24;
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
            r_top     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_empty   <= n_empty;
            r_top     <= n_top;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_hdr <= i_cfg_data;
            end
        end
        r_total    <= n_total;
        r_faddr    <= n_faddr;
        r_cur      <= n_cur;
        r_s        <= n_s;
        r_x        <= n_x;
        r_cnt      <= n_cnt;
        r_b        <= n_b;
        r_p        <= n_p;
        r_n        <= n_n;
        r_mp       <= n_mp;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_m_data   <= n_m_data;
    end

endmodule
